// File: rtl/tccs_pkg.sv
// Shared types and constants for the text console core.
// No dependencies; imported by the cursor unit, the top level and the checker.
package tccs_pkg;

  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;
  localparam int CHAR_W    = 8;
  localparam int OP_W      = 2;
  localparam int ADDR_IN_W = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // What one put does to the cell store.
  typedef struct packed {
    logic write_cell;
    logic blank_cell;
    logic scroll;
  } cell_plan_t;

endpackage

// File: rtl/tccs_cursor.sv
// Cursor unit: holds row, column and row base address, and plans the cell write
// and scroll that a put causes. Depends on tccs_pkg.
module tccs_cursor import tccs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                put_en,
  input  logic                                clear_en,
  input  logic [CHAR_W-1:0]                   char_code,
  output cell_plan_t                          plan,
  output logic [$clog2(ROWS*COLUMNS)-1:0]     write_addr,
  output logic [$clog2(ROWS)-1:0]             row,
  output logic [$clog2(COLUMNS)-1:0]          col
);

  localparam int AW = $clog2(ROWS * COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);

  logic [AW-1:0] row_base;
  logic [AW-1:0] row_base_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_next;
  logic [AW-1:0] here;
  logic          advance;

  assign here = row_base + AW'(col);

  always_comb begin
    plan          = '0;
    write_addr    = here;
    advance       = 1'b0;
    row_next      = row;
    col_next      = col;
    row_base_next = row_base;
    if (char_code == CHAR_NEWLINE) begin
      advance = 1'b1;
    end else if (char_code == CHAR_BACKSPACE) begin
      if (col != '0) begin
        plan.write_cell = 1'b1;
        plan.blank_cell = 1'b1;
        write_addr      = here - AW'(1);
        col_next        = col - CW'(1);
      end
    end else begin
      plan.write_cell = 1'b1;
      if (col == CW'(COLUMNS - 1)) begin
        advance = 1'b1;
      end else begin
        col_next = col + CW'(1);
      end
    end
    if (advance) begin
      col_next = '0;
      // On the last row the cursor stays on that row and the screen moves up instead.
      if (row == RW'(ROWS - 1)) begin
        plan.scroll = 1'b1;
      end else begin
        row_next      = row + RW'(1);
        row_base_next = row_base + AW'(COLUMNS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_en) begin
      row      <= '0;
      col      <= '0;
      row_base <= '0;
    end else if (put_en) begin
      row      <= row_next;
      col      <= col_next;
      row_base <= row_base_next;
    end
  end

endmodule

// File: rtl/text_console_cursor_scroll_core.sv
// Top level of the text console: cell memory, scroll/clear sequencer and output register.
// Depends on tccs_pkg and tccs_cursor.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, operation, char_code,      | into core
//          | cell_address                                   |
//  out     | out_valid, out_ready, cursor_row,              | out of core
//          | cursor_column, read_cell                       |
//  cfg     | cfg_valid, cfg_ready, cfg_data                 | into core
//
// A put that does not scroll, an out-of-range read or an unused code goes straight to the
// finish state; an in-range read first passes through a read-wait state. A scroll copies
// ROWS*COLUMNS-COLUMNS cells through the single read port and then blanks the bottom row.
// A clear sweeps every cell. One item is in work at a time; in_ready is high when idle.
// After reset the cursor is home and the cells are undefined until cleared or written.
// A result held by a low out_ready stalls the next item only in its finish state, ST_FINISH.
module text_console_cursor_scroll_core import tccs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      operation,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [ADDR_IN_W-1:0] cell_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_OUT_W-1:0] cursor_row,
  output logic [COL_OUT_W-1:0] cursor_column,
  output logic [CELL_W-1:0]    read_cell,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ATTR_W-1:0]    cfg_data
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int PW = $clog2(CELL_COUNT + 1);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RDWAIT = 3'd1;
  localparam logic [2:0] ST_COPY   = 3'd2;
  localparam logic [2:0] ST_BLANK  = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]        state;
  logic [ATTR_W-1:0] attr;
  logic [PW-1:0]     ptr;
  logic              rd_pending;
  logic [AW-1:0]     copy_dst;
  logic              read_hit;

  logic [CELL_W-1:0] cells [CELL_COUNT];
  logic [CELL_W-1:0] rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;

  logic              in_fire;
  logic              in_range;
  logic              out_free;
  logic [CELL_W-1:0] blank;
  cell_plan_t        plan;
  logic [AW-1:0]     put_addr;
  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     cur_col;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign in_range  = (32'(cell_address) < 32'(CELL_COUNT));
  assign out_free  = !out_valid || out_ready;
  assign blank     = {attr, CHAR_SPACE};

  tccs_cursor #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .put_en    (in_fire && (operation == OP_PUT)),
    .clear_en  (in_fire && (operation == OP_CLEAR)),
    .char_code (char_code),
    .plan      (plan),
    .write_addr(put_addr),
    .row       (cur_row),
    .col       (cur_col)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr <= cfg_data;
    end
  end

  // Memory port selection. During a scroll the read runs one cell ahead of the
  // write, and a destination always lies below every source still to be read.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(ptr);
    wr_en   = 1'b0;
    wr_addr = AW'(ptr);
    wr_data = blank;
    unique case (state)
      ST_IDLE: begin
        rd_en   = in_fire && (operation == OP_READ) && in_range;
        rd_addr = AW'(cell_address);
        wr_en   = in_fire && (operation == OP_PUT) && plan.write_cell;
        wr_addr = put_addr;
        wr_data = plan.blank_cell ? blank : {attr, char_code};
      end
      ST_COPY: begin
        rd_en   = (ptr != PW'(CELL_COUNT));
        wr_en   = rd_pending;
        wr_addr = copy_dst;
        wr_data = rd_data;
      end
      ST_BLANK, ST_CLEAR: begin
        wr_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= cells[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= (state == ST_COPY) && rd_en;
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (operation == OP_READ && in_range) begin
              read_hit <= 1'b1;
              state    <= ST_RDWAIT;
            end else begin
              read_hit <= 1'b0;
              if (operation == OP_CLEAR) begin
                ptr   <= '0;
                state <= ST_CLEAR;
              end else if (operation == OP_PUT && plan.scroll) begin
                ptr   <= PW'(COLUMNS);
                state <= ST_COPY;
              end else begin
                state <= ST_FINISH;
              end
            end
          end
        end
        ST_RDWAIT: begin
          state <= ST_FINISH;
        end
        ST_COPY: begin
          if (rd_en) begin
            copy_dst <= AW'(ptr - PW'(COLUMNS));
            ptr      <= ptr + PW'(1);
          end else begin
            ptr   <= PW'(CELL_COUNT - COLUMNS);
            state <= ST_BLANK;
          end
        end
        ST_BLANK, ST_CLEAR: begin
          ptr <= ptr + PW'(1);
          if (ptr == PW'(CELL_COUNT - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            cursor_row    <= ROW_OUT_W'(cur_row);
            cursor_column <= COL_OUT_W'(cur_col);
            read_cell     <= read_hit ? rd_data : '0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/tccs_checker.sv
// Port-level checker for the text console core, bound to the top level.
// Depends on tccs_pkg and text_console_cursor_scroll_core.
module tccs_checker import tccs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ROW_OUT_W-1:0] cursor_row,
  input logic [COL_OUT_W-1:0] cursor_column,
  input logic [CELL_W-1:0]    read_cell
);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_row)
      && $stable(cursor_column) && $stable(read_cell))
    else $error("result changed while stalled");

  // One item at a time: an accepted item closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // Reset leaves no result pending and the core ready.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("core not idle after reset");

  // The reported cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((COLUMNS > 127) || (32'(cursor_column) < 32'(COLUMNS)))
      && ((ROWS > 31) || (32'(cursor_row) < 32'(ROWS))))
    else $error("cursor off the screen");

endmodule

bind text_console_cursor_scroll_core tccs_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tccs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .cursor_row   (cursor_row),
  .cursor_column(cursor_column),
  .read_cell    (read_cell)
);

// File: verif/text_console_cursor_scroll_checker.sv
// Checker for the text console core: watches the input, output and config channels,
// keeps its own screen, cursor and attribute, and compares every result item.
// Depends on tccs_pkg.
`timescale 1ns / 100ps

module text_console_cursor_scroll_checker import tccs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [OP_W-1:0]      operation,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [ADDR_IN_W-1:0] cell_address,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [ROW_OUT_W-1:0] cursor_row,
  input  logic [COL_OUT_W-1:0] cursor_column,
  input  logic [CELL_W-1:0]    read_cell,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [ATTR_W-1:0]    cfg_data,
  output int                   reply_backlog,
  output int                   error_count
);

  localparam int CELLS = ROWS * COLUMNS;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [CELL_W-1:0]    cell_word;
  } console_reply_t;

  logic [CELL_W-1:0] screen_mem [CELLS];
  logic [ATTR_W-1:0] attr;
  int                cur_row;
  int                cur_col;
  console_reply_t    pending_replies [$];
  console_reply_t    want;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t ns: %s", $time, what);
  endtask

  // Cursor to column 0 of the next row; past the bottom the screen scrolls up a row.
  task automatic next_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
      for (int c = 0; c < COLUMNS; c++) screen_mem[CELLS - COLUMNS + c] = {attr, CHAR_SPACE};
      cur_row = ROWS - 1;
    end
  endtask

  task automatic console_step(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [ADDR_IN_W-1:0] addr);
    console_reply_t r;
    r.cell_word = '0;
    case (op)
      OP_PUT: begin
        if (ch == CHAR_NEWLINE) begin
          next_row();
        end else if (ch == CHAR_BACKSPACE) begin
          // A backspace at column 0 leaves both the cursor and the screen alone.
          if (cur_col > 0) begin
            cur_col--;
            screen_mem[cur_row * COLUMNS + cur_col] = {attr, CHAR_SPACE};
          end
        end else begin
          screen_mem[cur_row * COLUMNS + cur_col] = {attr, ch};
          cur_col++;
          if (cur_col >= COLUMNS) next_row();
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_mem[i] = {attr, CHAR_SPACE};
        cur_row = 0;
        cur_col = 0;
      end
      OP_READ: begin
        if (int'(addr) < CELLS) r.cell_word = screen_mem[addr];
      end
      default: ;
    endcase
    r.row = ROW_OUT_W'(cur_row);
    r.col = COL_OUT_W'(cur_col);
    pending_replies.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen_mem[i] = '0;
      attr = ATTR_RESET;
      cur_row = 0;
      cur_col = 0;
      error_count = 0;
      pending_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) attr = cfg_data;
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("result item with none expected: row %0d col %0d cell 0x%04h",
                                    cursor_row, cursor_column, read_cell));
        end else begin
          want = pending_replies.pop_front();
          if (cursor_row !== want.row)
            report_mismatch($sformatf("cursor_row got %0d, expected %0d", cursor_row, want.row));
          if (cursor_column !== want.col)
            report_mismatch($sformatf("cursor_column got %0d, expected %0d",
                                      cursor_column, want.col));
          if (read_cell !== want.cell_word)
            report_mismatch($sformatf("read_cell got 0x%04h, expected 0x%04h",
                                      read_cell, want.cell_word));
        end
      end
      if (in_valid && in_ready) console_step(operation, char_code, cell_address);
    end
    reply_backlog <= pending_replies.size();
  end

endmodule

// File: verif/text_console_cursor_scroll_core_tb.sv
// Testbench top for the text console core: clock, reset, stimulus and the verdict.
// Depends on tccs_pkg, text_console_cursor_scroll_core and text_console_cursor_scroll_checker.
`timescale 1ns / 100ps

module text_console_cursor_scroll_core_tb;
  import tccs_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = ROWS * COLUMNS;
  localparam int LONG_HOLD   = 400;
  localparam int QUIET_LIMIT = 20000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      operation;
  logic [CHAR_W-1:0]    char_code;
  logic [ADDR_IN_W-1:0] cell_address;
  logic                 out_valid;
  logic                 out_ready;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [COL_OUT_W-1:0] cursor_column;
  logic [CELL_W-1:0]    read_cell;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [ATTR_W-1:0]    cfg_data;

  int results_due;
  int error_count;
  int items_sent    = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int quiet_cycles  = 0;
  bit calm          = 1'b0;

  always #10 clk = ~clk;

  text_console_cursor_scroll_core #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .char_code(char_code), .cell_address(cell_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .cursor_row(cursor_row), .cursor_column(cursor_column), .read_cell(read_cell),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  text_console_cursor_scroll_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .char_code(char_code), .cell_address(cell_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .cursor_row(cursor_row), .cursor_column(cursor_column), .read_cell(read_cell),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .reply_backlog(results_due), .error_count(error_count)
  );

  // Ends the run if no channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("text_console_cursor_scroll_core_tb: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request from the sender.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_served++;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic send_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                         input logic [ADDR_IN_W-1:0] addr);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    char_code    <= ch;
    cell_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_op(OP_PUT, ch, ADDR_IN_W'($urandom));
  endtask

  task automatic read_at(input logic [ADDR_IN_W-1:0] addr);
    send_op(OP_READ, CHAR_W'($urandom), addr);
  endtask

  task automatic clear_screen();
    send_op(OP_CLEAR, CHAR_W'($urandom), ADDR_IN_W'($urandom));
  endtask

  // Stop offering items and wait until every expected result item has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int  target;
    int  len;
    bit  hold_asked;
    rst          = 1'b1;
    in_valid     = 1'b0;
    operation    = OP_PUT;
    char_code    = '0;
    cell_address = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    hold_asked   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting under the reset attribute. The first item is a clear, so no cell
    // is ever read or scrolled before it has been written.
    clear_screen();
    read_at(0);
    put_char(8'h41);
    read_at(0);
    put_char(CHAR_BACKSPACE);
    put_char(CHAR_BACKSPACE);
    put_char(8'h00);
    put_char(8'hFF);
    read_at(1);
    put_char(CHAR_NEWLINE);
    read_at(ADDR_IN_W'(CELLS - 1));
    read_at(ADDR_IN_W'(CELLS));
    read_at('1);
    send_op(OP_UNUSED, '1, '1);
    settle();
    write_attr(8'h00);
    put_char(CHAR_SPACE);
    read_at(ADDR_IN_W'(COLUMNS));
    clear_screen();
    read_at(ADDR_IN_W'(CELLS - 1));
    settle();
    write_attr(8'hFF);
    put_char(8'h7E);
    put_char(CHAR_BACKSPACE);
    read_at(0);
    clear_screen();
    read_at(0);

    // Random part: mostly text lines with some backspaces, runs of newlines that
    // push the cursor to the bottom and scroll, reads, and a little noise.
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      write_attr(ATTR_W'($urandom_range(0, 255)));
      calm   = (phase == 3);
      target = items_sent + 160;
      while (items_sent < target) begin
        if (phase == 1 && !hold_asked && items_sent > target - 90) begin
          hold_requests++;
          hold_asked = 1'b1;
        end
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 24);
            repeat (len) begin
              if ($urandom_range(0, 9) == 0) put_char(CHAR_BACKSPACE);
              else put_char(CHAR_W'($urandom));
            end
            if ($urandom_range(0, 3) != 0) put_char(CHAR_NEWLINE);
          end
          10, 11, 12, 13: begin
            repeat ($urandom_range(1, 6)) begin
              if ($urandom_range(0, 4) == 0) read_at(ADDR_IN_W'($urandom_range(CELLS, 2047)));
              else read_at(ADDR_IN_W'($urandom_range(0, CELLS - 1)));
            end
          end
          14, 15, 16: begin
            repeat ($urandom_range(1, 6)) put_char(CHAR_NEWLINE);
          end
          17: begin
            repeat ($urandom_range(1, 5)) put_char(CHAR_BACKSPACE);
          end
          18: begin
            if ($urandom_range(0, 2) == 0) clear_screen();
            else send_op(OP_UNUSED, CHAR_W'($urandom), ADDR_IN_W'($urandom));
          end
          default: begin
            send_op(OP_W'($urandom), CHAR_W'($urandom), ADDR_IN_W'($urandom));
          end
        endcase
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("text_console_cursor_scroll_core_tb: done, clean");
    end else begin
      $display("text_console_cursor_scroll_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: text_console_cursor_scroll_core.f
rtl/tccs_pkg.sv
rtl/tccs_cursor.sv
rtl/text_console_cursor_scroll_core.sv
rtl/tccs_checker.sv
verif/text_console_cursor_scroll_checker.sv
verif/text_console_cursor_scroll_core_tb.sv
